/* hw/rtl/flba_pkg.sv */
// ----------------------------------------------------------------------------
// flba_pkg
// Shared types and constants for the free list block allocator.
// ----------------------------------------------------------------------------
package flba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int COUNT_W        = 9;
  localparam int COUNT_RESET    = 256;
  localparam int INDEX_W        = 8;

  localparam logic OP_TAKE   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_write;
    logic do_return;
    logic take_read;
    logic take_empty;
    logic take_finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic head_valid;
  } stat_t;

endpackage

/* hw/rtl/flba_dp.sv */
// ----------------------------------------------------------------------------
// flba_dp
// Datapath: link memory, free list head, block count, init sweep counter
// and result register.
// ----------------------------------------------------------------------------
module flba_dp #(
  parameter int MAX_BLOCKS = flba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  flba_pkg::cmd_t               cmd,
  output flba_pkg::stat_t              stat,
  input  logic [flba_pkg::COUNT_W-1:0] block_count,
  input  logic [flba_pkg::INDEX_W-1:0] return_index,
  output logic                         granted,
  output logic [flba_pkg::INDEX_W-1:0] block_index,
  output logic [1:0]                   status,
  output logic                         pool_empty
);

  localparam int IW      = $clog2(MAX_BLOCKS);
  localparam int CW      = $clog2(MAX_BLOCKS + 1);
  localparam int RST_CNT = (flba_pkg::COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS
                                                                : flba_pkg::COUNT_RESET;

  logic [IW:0]    mem [MAX_BLOCKS];
  logic [IW:0]    rd_data;
  logic [CW-1:0]  count;
  logic [CW-1:0]  sweep_cnt;
  logic [CW-1:0]  sweep_nxt;
  logic [CW-1:0]  count_sat;
  logic           head_valid;
  logic [IW-1:0]  head_idx;
  logic           ret_ok;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [IW:0]    mem_wdata;

  assign count_sat = (32'(block_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                          : CW'(block_count);
  assign sweep_nxt = CW'(sweep_cnt + CW'(1));
  assign ret_ok    = 32'(return_index) < 32'(count);

  assign stat.sweep_done = (sweep_cnt == count);
  assign stat.head_valid = head_valid;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_cnt[IW-1:0];
    mem_wdata = {(sweep_nxt < count), sweep_nxt[IW-1:0]};
    if (cmd.sweep_write) begin
      mem_we = 1'b1;
    end else if (cmd.do_return && ret_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(return_index);
      mem_wdata = {head_valid, head_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.take_read) begin
      rd_data <= mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= CW'(RST_CNT);
      sweep_cnt  <= '0;
      head_valid <= 1'b1;
      head_idx   <= '0;
    end else if (cmd.sweep_start) begin
      count      <= count_sat;
      sweep_cnt  <= '0;
      head_valid <= (count_sat != '0);
      head_idx   <= '0;
    end else begin
      if (cmd.sweep_write) begin
        sweep_cnt <= sweep_nxt;
      end
      if (cmd.do_return && ret_ok) begin
        head_valid <= 1'b1;
        head_idx   <= IW'(return_index);
      end else if (cmd.take_finish) begin
        head_valid <= rd_data[IW];
        head_idx   <= rd_data[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_return) begin
      granted     <= 1'b0;
      block_index <= '0;
      status      <= ret_ok ? flba_pkg::ST_OK : flba_pkg::ST_RANGE;
      pool_empty  <= ret_ok ? 1'b0 : !head_valid;
    end else if (cmd.take_empty) begin
      granted     <= 1'b0;
      block_index <= '0;
      status      <= flba_pkg::ST_EMPTY;
      pool_empty  <= 1'b1;
    end else if (cmd.take_finish) begin
      granted     <= 1'b1;
      block_index <= flba_pkg::INDEX_W'(head_idx);
      status      <= flba_pkg::ST_OK;
      pool_empty  <= !rd_data[IW];
    end
  end

endmodule

/* hw/rtl/flba_ctrl.sv */
// ----------------------------------------------------------------------------
// flba_ctrl
// Controller: init sweep, take/return sequencing and channel handshakes.
// ----------------------------------------------------------------------------
module flba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            opcode,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  flba_pkg::stat_t stat,
  output flba_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_TAKE
  } state_t;

  state_t state;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.sweep_start = cfg_valid;
    cmd.sweep_write = (state == S_INIT) && !stat.sweep_done && !cfg_valid;
    cmd.do_return   = accept && (opcode == flba_pkg::OP_RETURN);
    cmd.take_read   = accept && (opcode == flba_pkg::OP_TAKE) && stat.head_valid;
    cmd.take_empty  = accept && (opcode == flba_pkg::OP_TAKE) && !stat.head_valid;
    cmd.take_finish = (state == S_TAKE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        state <= S_INIT;
      end else begin
        unique case (state)
          S_INIT: begin
            if (stat.sweep_done) state <= S_IDLE;
          end
          S_IDLE: begin
            if (cmd.take_read) state <= S_TAKE;
          end
          S_TAKE: begin
            state <= S_IDLE;
          end
          default: begin
            state <= S_INIT;
          end
        endcase
      end
      if (cmd.do_return || cmd.take_empty || cmd.take_finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/free_list_block_allocator.sv */
// A return beat or a take on an empty pool gives its result in the cycle
// after acceptance; a granting take reads the link memory into rd_data, then
// sets the result in S_TAKE. Throughput: one return or empty take per cycle
// while out_ready stays high; one item in flight, next taken once the result
// register is free. Reset or a block_count write starts an init sweep, one
// link write per block, that builds the chain; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
// free_list_block_allocator
// Fixed-size block pool allocator on a LIFO free list of block indices.
// ----------------------------------------------------------------------------
module free_list_block_allocator #(
  parameter int MAX_BLOCKS = flba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [flba_pkg::COUNT_W-1:0] block_count,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [flba_pkg::INDEX_W-1:0] return_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output logic [flba_pkg::INDEX_W-1:0] block_index,
  output logic [1:0]                   status,
  output logic                         pool_empty
);

  flba_pkg::cmd_t  cmd;
  flba_pkg::stat_t stat;

  flba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  flba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .block_count  (block_count),
    .return_index (return_index),
    .granted      (granted),
    .block_index  (block_index),
    .status       (status),
    .pool_empty   (pool_empty)
  );

  a_return_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == flba_pkg::OP_RETURN) && !cfg_valid)
      |=> out_valid)
    else $error("return beat did not produce a result");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (status == flba_pkg::ST_OK))
    else $error("granted result with error status");

  a_no_grant_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (block_index == '0))
    else $error("nonzero block_index without grant");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == flba_pkg::ST_EMPTY)) |-> pool_empty)
    else $error("empty take but pool not reported empty");

endmodule
